@@ design/first_fit_allocator_with_eviction_assert.svh @@
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef FIRST_FIT_ALLOCATOR_WITH_EVICTION_ASSERT_SVH
`define FIRST_FIT_ALLOCATOR_WITH_EVICTION_ASSERT_SVH

// Plain property that must hold at every clock edge out of reset.
`define FFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define FFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/ffa_pkg.sv @@
// Shared types and codes for the first-fit allocator.
// No dependencies; imported by the controller, datapath and top level.
package ffa_pkg;

    localparam logic [1:0] CMD_PLACE  = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [2:0] ST_PLACED   = 3'd0;
    localparam logic [2:0] ST_RESIDENT = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_TOOBIG   = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_TICKED   = 3'd6;

    localparam logic [15:0] RESET_TOTAL = 16'd1024;

    // datapath operations
    localparam logic [4:0] OP_NOP        = 5'd0;
    localparam logic [4:0] OP_ACCEPT     = 5'd1;
    localparam logic [4:0] OP_RD_IDX     = 5'd2;
    localparam logic [4:0] OP_IDX_INC    = 5'd3;
    localparam logic [4:0] OP_IDX_CLR    = 5'd4;
    localparam logic [4:0] OP_TAKE_HIT   = 5'd5;
    localparam logic [4:0] OP_BEST       = 5'd6;
    localparam logic [4:0] OP_TICK       = 5'd7;
    localparam logic [4:0] OP_TAKE_BEST  = 5'd8;
    localparam logic [4:0] OP_FREE0      = 5'd9;
    localparam logic [4:0] OP_RD_NEXT    = 5'd10;
    localparam logic [4:0] OP_MERGE_NEXT = 5'd11;
    localparam logic [4:0] OP_RD_PREV    = 5'd12;
    localparam logic [4:0] OP_MERGE_PREV = 5'd13;
    localparam logic [4:0] OP_WR_CUR     = 5'd14;
    localparam logic [4:0] OP_DEL_RD     = 5'd15;
    localparam logic [4:0] OP_DEL_WR     = 5'd16;
    localparam logic [4:0] OP_DEL_FIN    = 5'd17;
    localparam logic [4:0] OP_INS_START  = 5'd18;
    localparam logic [4:0] OP_INS_RD     = 5'd19;
    localparam logic [4:0] OP_INS_WR     = 5'd20;
    localparam logic [4:0] OP_INS_FIN    = 5'd21;
    localparam logic [4:0] OP_PL_WR      = 5'd22;
    localparam logic [4:0] OP_EMIT       = 5'd23;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] st;
        logic       ev;
    } t_ffa_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       init_pend;
        logic       owned_hit;
        logic       fit_hit;
        logic       rd_hole;
        logic       idx_last;
        logic       bad_size;
        logic       best_v;
        logic       has_next;
        logic       pos_zero;
        logic       del_more;
        logic       ins_more;
        logic       split;
        logic       full;
        logic       out_free;
    } t_ffa_sts;

endpackage

@@ design/ffa_datapath.sv @@
// Segment table memory, counters, request and result registers.
// Depends on ffa_pkg and the assertion macro header.
`include "first_fit_allocator_with_eviction_assert.svh"

module ffa_datapath import ffa_pkg::*; #(
    parameter int MAX_SEGS = 32,
    parameter int AGE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_cmd,
    input  logic [15:0]          i_process_id,
    input  logic [15:0]          i_req_size,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_out_stall,
    input  t_ffa_ctl             i_ctl,
    output t_ffa_sts             o_sts,
    output logic                 o_out_valid,
    output logic                 o_evicted_valid,
    output logic [15:0]          o_evicted_id,
    output logic [2:0]           o_status,
    output logic                 o_last,
    output logic [5:0]           o_proc_count,
    output logic [5:0]           o_hole_count,
    output logic [15:0]          o_used_memory
);

    localparam int IW  = $clog2(MAX_SEGS);
    localparam int CW  = $clog2(MAX_SEGS + 1);
    localparam int CW1 = CW + 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic [16:0]         m_own [MAX_SEGS];
    logic [15:0]         m_len [MAX_SEGS];
    logic [AGE_BITS-1:0] m_age [MAX_SEGS];

    logic [16:0]         r_rd_own;
    logic [15:0]         r_rd_len;
    logic [AGE_BITS-1:0] r_rd_age;

    logic [15:0]   r_total;
    logic [CW-1:0] r_cnt, r_res, r_holes;
    logic [15:0]   r_occ;
    logic          r_init;
    logic [1:0]    r_cmd;
    logic [15:0]   r_id, r_size;
    logic [IW-1:0] r_idx, r_pos, r_j;
    logic [16:0]   r_cur_own;
    logic [15:0]   r_cur_len;
    logic          r_bv;
    logic [IW-1:0] r_bidx;
    logic [15:0]   r_blen, r_bid;
    logic [AGE_BITS-1:0] r_bage;

    logic          r_o_v, r_o_ev, r_o_last;
    logic [15:0]   r_o_id, r_o_used;
    logic [2:0]    r_o_st;
    logic [5:0]    r_o_pc, r_o_hc;

    logic                rd_en, wr_en, better, out_free, cfg_ok;
    logic [IW-1:0]       rd_addr, wr_addr;
    logic [16:0]         wr_own;
    logic [15:0]         wr_len;
    logic [AGE_BITS-1:0] wr_age;

    assign cfg_ok   = i_cfg_we && (i_cfg_data != 16'd0);
    assign out_free = !r_o_v || !i_out_stall;
    assign better   = r_rd_own[16] && (!r_bv || (r_rd_len > r_blen) ||
                      ((r_rd_len == r_blen) && (r_rd_age > r_bage)));

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.init_pend = r_init;
        o_sts.owned_hit = (r_rd_own == {1'b1, r_id});
        o_sts.rd_hole   = !r_rd_own[16];
        o_sts.fit_hit   = !r_rd_own[16] && (r_rd_len >= r_size);
        o_sts.idx_last  = (CW1'(r_idx) + CW1'(1)) == CW1'(r_cnt);
        o_sts.bad_size  = (r_size == 16'd0) || (r_size > r_total);
        o_sts.best_v    = r_bv;
        o_sts.has_next  = (CW1'(r_pos) + CW1'(1)) < CW1'(r_cnt);
        o_sts.pos_zero  = (r_pos == '0);
        o_sts.del_more  = (CW1'(r_j) + CW1'(1)) < CW1'(r_cnt);
        o_sts.ins_more  = CW1'(r_j) > (CW1'(r_pos) + CW1'(1));
        o_sts.split     = r_cur_len > r_size;
        o_sts.full      = r_cnt >= CW'(MAX_SEGS);
        o_sts.out_free  = out_free;
    end

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_idx;
        case (i_ctl.op)
            OP_RD_IDX:  rd_addr = r_idx;
            OP_RD_NEXT: rd_addr = r_pos + IW'(1);
            OP_RD_PREV: rd_addr = r_pos - IW'(1);
            OP_DEL_RD:  rd_addr = r_j + IW'(1);
            OP_INS_RD:  rd_addr = r_j - IW'(1);
            default:    rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_pos;
        wr_own  = 17'd0;
        wr_len  = r_cur_len;
        wr_age  = '0;
        if (r_init || cfg_ok) begin
            wr_addr = '0;
            wr_len  = cfg_ok ? i_cfg_data : r_total;
        end else begin
            case (i_ctl.op)
                OP_TICK: begin
                    wr_en   = r_rd_own[16] && (r_rd_age != AGE_MAX);
                    wr_addr = r_idx;
                    wr_own  = r_rd_own;
                    wr_len  = r_rd_len;
                    wr_age  = r_rd_age + AGE_BITS'(1);
                end
                OP_WR_CUR: wr_own = r_cur_own;
                OP_MERGE_PREV: begin
                    wr_addr = r_pos - IW'(1);
                    wr_len  = r_rd_len + r_cur_len;
                end
                OP_DEL_WR, OP_INS_WR: begin
                    wr_addr = r_j;
                    wr_own  = r_rd_own;
                    wr_len  = r_rd_len;
                    wr_age  = r_rd_age;
                end
                OP_INS_FIN: begin
                    wr_addr = r_pos + IW'(1);
                    wr_len  = r_cur_len - r_size;
                end
                OP_PL_WR: begin
                    wr_own = {1'b1, r_id};
                    wr_len = r_size;
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_own[wr_addr] <= wr_own;
            m_len[wr_addr] <= wr_len;
            m_age[wr_addr] <= wr_age;
        end
        if (rd_en) begin
            r_rd_own <= m_own[rd_addr];
            r_rd_len <= m_len[rd_addr];
            r_rd_age <= m_age[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= RESET_TOTAL;
            r_cnt    <= CW'(1);
            r_res    <= '0;
            r_holes  <= CW'(1);
            r_occ    <= '0;
            r_init   <= 1'b1;
            r_o_v    <= 1'b0;
            r_bv     <= 1'b0;
        end else begin
            r_init <= 1'b0;
            if (r_o_v && !i_out_stall) begin
                r_o_v <= 1'b0;
            end
            if (cfg_ok) begin
                r_total <= i_cfg_data;
                r_cnt   <= CW'(1);
                r_res   <= '0;
                r_holes <= CW'(1);
                r_occ   <= '0;
            end else begin
                case (i_ctl.op)
                    OP_ACCEPT: begin
                        r_cmd  <= i_cmd;
                        r_id   <= i_process_id;
                        r_size <= i_req_size;
                        r_idx  <= '0;
                    end
                    OP_IDX_INC, OP_TICK: r_idx <= r_idx + IW'(1);
                    OP_IDX_CLR: begin
                        r_idx <= '0;
                        r_bv  <= 1'b0;
                    end
                    OP_TAKE_HIT: begin
                        r_pos     <= r_idx;
                        r_cur_own <= r_rd_own;
                        r_cur_len <= r_rd_len;
                    end
                    OP_BEST: begin
                        if (better) begin
                            r_bv   <= 1'b1;
                            r_bidx <= r_idx;
                            r_blen <= r_rd_len;
                            r_bage <= r_rd_age;
                            r_bid  <= r_rd_own[15:0];
                        end
                        r_idx <= r_idx + IW'(1);
                    end
                    OP_TAKE_BEST: begin
                        r_pos     <= r_bidx;
                        r_cur_own <= {1'b1, r_bid};
                        r_cur_len <= r_blen;
                    end
                    OP_FREE0: begin
                        r_cur_own <= 17'd0;
                        r_res     <= r_res - CW'(1);
                        r_holes   <= r_holes + CW'(1);
                        r_occ     <= r_occ - r_cur_len;
                    end
                    OP_MERGE_NEXT: begin
                        r_cur_len <= r_cur_len + r_rd_len;
                        r_j       <= r_pos + IW'(1);
                        r_holes   <= r_holes - CW'(1);
                    end
                    OP_MERGE_PREV: begin
                        r_j     <= r_pos;
                        r_holes <= r_holes - CW'(1);
                    end
                    OP_DEL_WR:    r_j   <= r_j + IW'(1);
                    OP_DEL_FIN:   r_cnt <= r_cnt - CW'(1);
                    OP_INS_START: r_j   <= r_cnt[IW-1:0];
                    OP_INS_WR:    r_j   <= r_j - IW'(1);
                    OP_INS_FIN:   r_cnt <= r_cnt + CW'(1);
                    OP_PL_WR: begin
                        r_res <= r_res + CW'(1);
                        r_occ <= r_occ + r_size;
                        if (r_cur_len == r_size) begin
                            r_holes <= r_holes - CW'(1);
                        end
                    end
                    OP_EMIT: begin
                        r_idx    <= '0;
                        r_o_v    <= 1'b1;
                        r_o_ev   <= i_ctl.ev;
                        r_o_id   <= i_ctl.ev ? r_bid : 16'd0;
                        r_o_st   <= i_ctl.st;
                        r_o_last <= !i_ctl.ev;
                        r_o_pc   <= 6'(r_res);
                        r_o_hc   <= 6'(r_holes);
                        r_o_used <= r_occ;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid     = r_o_v;
    assign o_evicted_valid = r_o_ev;
    assign o_evicted_id    = r_o_id;
    assign o_status        = r_o_st;
    assign o_last          = r_o_last;
    assign o_proc_count    = r_o_pc;
    assign o_hole_count    = r_o_hc;
    assign o_used_memory   = r_o_used;

    `FFA_ASSERT(a_cnt_range, i_clk, i_rst_n, (r_cnt != '0) && (r_cnt <= CW'(MAX_SEGS)), "segment count out of range")
    `FFA_ASSERT(a_kinds_fit, i_clk, i_rst_n, (CW1'(r_res) + CW1'(r_holes)) <= CW1'(r_cnt), "holes plus blocks exceed segments")
    `FFA_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_ctl.op == OP_EMIT, out_free, "result loaded over a waiting one")
    `FFA_ASSERT_IMP(a_last_plain, i_clk, i_rst_n, r_o_v && r_o_last, !r_o_ev, "final result flagged as eviction")

endmodule

@@ design/ffa_ctrl.sv @@
// Sequencer for the allocator: scans, eviction loop, merge and split moves.
// Depends on ffa_pkg; drives ffa_datapath through t_ffa_ctl.
module ffa_ctrl import ffa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_cmd,
    input  t_ffa_sts   i_sts,
    output logic       o_in_stall,
    output t_ffa_ctl   o_ctl
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_F_RD   = 5'd1;
    localparam logic [4:0] S_F_EV   = 5'd2;
    localparam logic [4:0] S_FF_RD  = 5'd3;
    localparam logic [4:0] S_FF_EV  = 5'd4;
    localparam logic [4:0] S_V_RD   = 5'd5;
    localparam logic [4:0] S_V_EV   = 5'd6;
    localparam logic [4:0] S_V_DEC  = 5'd7;
    localparam logic [4:0] S_T_RD   = 5'd8;
    localparam logic [4:0] S_T_EV   = 5'd9;
    localparam logic [4:0] S_FR0    = 5'd10;
    localparam logic [4:0] S_FR1_RD = 5'd11;
    localparam logic [4:0] S_FR1_EV = 5'd12;
    localparam logic [4:0] S_FR2    = 5'd13;
    localparam logic [4:0] S_FR3_EV = 5'd14;
    localparam logic [4:0] S_DEL    = 5'd15;
    localparam logic [4:0] S_DEL_WR = 5'd16;
    localparam logic [4:0] S_PLACE  = 5'd17;
    localparam logic [4:0] S_INS    = 5'd18;
    localparam logic [4:0] S_INS_WR = 5'd19;
    localparam logic [4:0] S_PL     = 5'd20;
    localparam logic [4:0] S_EMIT   = 5'd21;

    logic [4:0] r_state, n_state;
    logic [2:0] r_est, n_est;
    logic       r_eev, n_eev;
    logic       r_ret, n_ret;
    logic       r_evict, n_evict;

    assign o_in_stall = (r_state != S_IDLE) || i_sts.init_pend;

    always_comb begin
        n_state  = r_state;
        n_est    = r_est;
        n_eev    = r_eev;
        n_ret    = r_ret;
        n_evict  = r_evict;
        o_ctl.op = OP_NOP;
        o_ctl.st = r_est;
        o_ctl.ev = r_eev;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_ctl.op = OP_ACCEPT;
                    n_eev    = 1'b0;
                    if (i_cmd inside {CMD_PLACE, CMD_REMOVE}) begin
                        n_state = S_F_RD;
                    end else if (i_cmd == CMD_TICK) begin
                        n_state = S_T_RD;
                    end
                end
            end
            S_F_RD: begin
                o_ctl.op = OP_RD_IDX;
                n_state  = S_F_EV;
            end
            S_F_EV: begin
                if (i_sts.owned_hit) begin
                    if (i_sts.cmd == CMD_PLACE) begin
                        n_est   = ST_RESIDENT;
                        n_state = S_EMIT;
                    end else begin
                        o_ctl.op = OP_TAKE_HIT;
                        n_evict  = 1'b0;
                        n_state  = S_FR0;
                    end
                end else if (i_sts.idx_last) begin
                    if (i_sts.cmd == CMD_REMOVE) begin
                        n_est   = ST_NOTFOUND;
                        n_state = S_EMIT;
                    end else if (i_sts.bad_size) begin
                        n_est   = ST_TOOBIG;
                        n_state = S_EMIT;
                    end else begin
                        o_ctl.op = OP_IDX_CLR;
                        n_state  = S_FF_RD;
                    end
                end else begin
                    o_ctl.op = OP_IDX_INC;
                    n_state  = S_F_RD;
                end
            end
            S_FF_RD: begin
                o_ctl.op = OP_RD_IDX;
                n_state  = S_FF_EV;
            end
            S_FF_EV: begin
                if (i_sts.fit_hit) begin
                    o_ctl.op = OP_TAKE_HIT;
                    n_state  = S_PLACE;
                end else if (i_sts.idx_last) begin
                    o_ctl.op = OP_IDX_CLR;
                    n_state  = S_V_RD;
                end else begin
                    o_ctl.op = OP_IDX_INC;
                    n_state  = S_FF_RD;
                end
            end
            S_V_RD: begin
                o_ctl.op = OP_RD_IDX;
                n_state  = S_V_EV;
            end
            S_V_EV: begin
                o_ctl.op = OP_BEST;
                n_state  = i_sts.idx_last ? S_V_DEC : S_V_RD;
            end
            S_V_DEC: begin
                if (i_sts.best_v) begin
                    o_ctl.op = OP_TAKE_BEST;
                    n_evict  = 1'b1;
                    n_state  = S_FR0;
                end else begin
                    n_est   = ST_TOOBIG;
                    n_state = S_EMIT;
                end
            end
            S_T_RD: begin
                o_ctl.op = OP_RD_IDX;
                n_state  = S_T_EV;
            end
            S_T_EV: begin
                o_ctl.op = OP_TICK;
                if (i_sts.idx_last) begin
                    n_est   = ST_TICKED;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_T_RD;
                end
            end
            S_FR0: begin
                o_ctl.op = OP_FREE0;
                n_state  = i_sts.has_next ? S_FR1_RD : S_FR2;
            end
            S_FR1_RD: begin
                o_ctl.op = OP_RD_NEXT;
                n_state  = S_FR1_EV;
            end
            S_FR1_EV: begin
                if (i_sts.rd_hole) begin
                    o_ctl.op = OP_MERGE_NEXT;
                    n_ret    = 1'b0;
                    n_state  = S_DEL;
                end else begin
                    n_state = S_FR2;
                end
            end
            S_FR2: begin
                if (i_sts.pos_zero) begin
                    o_ctl.op = OP_WR_CUR;
                    n_est    = r_evict ? ST_PLACED : ST_REMOVED;
                    n_eev    = r_evict;
                    n_state  = S_EMIT;
                end else begin
                    o_ctl.op = OP_RD_PREV;
                    n_state  = S_FR3_EV;
                end
            end
            S_FR3_EV: begin
                n_est = r_evict ? ST_PLACED : ST_REMOVED;
                n_eev = r_evict;
                if (i_sts.rd_hole) begin
                    o_ctl.op = OP_MERGE_PREV;
                    n_ret    = 1'b1;
                    n_state  = S_DEL;
                end else begin
                    o_ctl.op = OP_WR_CUR;
                    n_state  = S_EMIT;
                end
            end
            S_DEL: begin
                if (i_sts.del_more) begin
                    o_ctl.op = OP_DEL_RD;
                    n_state  = S_DEL_WR;
                end else begin
                    o_ctl.op = OP_DEL_FIN;
                    n_state  = r_ret ? S_EMIT : S_FR2;
                end
            end
            S_DEL_WR: begin
                o_ctl.op = OP_DEL_WR;
                n_state  = S_DEL;
            end
            S_PLACE: begin
                if (i_sts.split) begin
                    if (i_sts.full) begin
                        n_est   = ST_FULL;
                        n_state = S_EMIT;
                    end else begin
                        o_ctl.op = OP_INS_START;
                        n_state  = S_INS;
                    end
                end else begin
                    o_ctl.op = OP_PL_WR;
                    n_est    = ST_PLACED;
                    n_state  = S_EMIT;
                end
            end
            S_INS: begin
                if (i_sts.ins_more) begin
                    o_ctl.op = OP_INS_RD;
                    n_state  = S_INS_WR;
                end else begin
                    o_ctl.op = OP_INS_FIN;
                    n_state  = S_PL;
                end
            end
            S_INS_WR: begin
                o_ctl.op = OP_INS_WR;
                n_state  = S_INS;
            end
            S_PL: begin
                o_ctl.op = OP_PL_WR;
                n_est    = ST_PLACED;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.op = OP_EMIT;
                    n_eev    = 1'b0;
                    n_state  = r_eev ? S_FF_RD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_est   <= ST_PLACED;
            r_eev   <= 1'b0;
            r_ret   <= 1'b0;
            r_evict <= 1'b0;
        end else begin
            r_state <= n_state;
            r_est   <= n_est;
            r_eev   <= n_eev;
            r_ret   <= n_ret;
            r_evict <= n_evict;
        end
    end

endmodule

@@ design/first_fit_allocator_with_eviction.sv @@
// Table entries are scanned one at a time, each read and then evaluated; after each
// eviction the block scans the table again for a first fit.
// Throughput: one request at a time; the result register frees the input early.
// Reset (synchronous, active low) restores a 1024-unit hole; after it, entry zero
// is written while requests are held off.
module first_fit_allocator_with_eviction import ffa_pkg::*; #(
    parameter int MAX_SEGS = 32,
    parameter int AGE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_process_id,
    input  logic [15:0] i_req_size,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_evicted_valid,
    output logic [15:0] o_evicted_id,
    output logic [2:0]  o_status,
    output logic        o_last,
    output logic [5:0]  o_proc_count,
    output logic [5:0]  o_hole_count,
    output logic [15:0] o_used_memory
);

    // command from the sequencer, flags back from the table
    t_ffa_ctl ctl;
    t_ffa_sts sts;

    // Sequencer: decide scan, evict, merge and split moves per cycle.
    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_ctl      (ctl)
    );

    // Datapath: hold the table, counts and the result register.
    ffa_datapath #(
        .MAX_SEGS (MAX_SEGS),
        .AGE_BITS (AGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_process_id    (i_process_id),
        .i_req_size      (i_req_size),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .o_status        (o_status),
        .o_last          (o_last),
        .o_proc_count    (o_proc_count),
        .o_hole_count    (o_hole_count),
        .o_used_memory   (o_used_memory)
    );

endmodule

@@ sim/tb_first_fit_allocator_with_eviction.sv @@
// Self-checking testbench for the first-fit allocator with eviction.
// Depends on ffa_pkg and the first_fit_allocator_with_eviction RTL.
`timescale 1ns / 1ps

module tb_first_fit_allocator_with_eviction;
    import ffa_pkg::*;

    localparam int NSEG      = 32;
    localparam int SETTLE    = 400;    // idle cycles before a size write
    localparam int WD_LIMIT  = 80000;  // cycles without any handshake
    localparam int HOLD_LEN  = 2500;   // long receiver hold-off
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {K_REQ, K_CFG, K_DRAIN} t_kind;

    typedef struct {
        t_kind       kind;
        logic [1:0]  cmd;
        logic [15:0] pid;
        logic [15:0] size;
    } t_job;

    typedef struct {
        logic        ev;
        logic [15:0] eid;
        logic [2:0]  st;
        logic        last;
        logic [5:0]  procs;
        logic [5:0]  holes;
        logic [15:0] used;
    } t_alloc_res;

    // DUT signals; the inputs driven here are known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  cmd = '0;
    logic [15:0] pid = '0;
    logic [15:0] req_size = '0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    logic        o_evicted_valid;
    logic [15:0] o_evicted_id;
    logic [2:0]  o_status;
    logic        o_last;
    logic [5:0]  o_proc_count;
    logic [5:0]  o_hole_count;
    logic [15:0] o_used_memory;

    first_fit_allocator_with_eviction uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (cmd),
        .i_process_id   (pid),
        .i_req_size     (req_size),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_id   (o_evicted_id),
        .o_status       (o_status),
        .o_last         (o_last),
        .o_proc_count   (o_proc_count),
        .o_hole_count   (o_hole_count),
        .o_used_memory  (o_used_memory)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Shadow segment table: address ordered, owner bit 16 marks a block
    // ---------------------------------------------------------------
    logic [16:0] tbl_owner [NSEG];
    logic [15:0] tbl_len   [NSEG];
    logic [31:0] tbl_age   [NSEG];
    int          n_segs;
    logic [5:0]  n_procs;
    logic [5:0]  n_holes;
    logic [15:0] units_used;
    logic [15:0] total_units;

    t_job        pending[$];     // requests and size writes still to drive
    t_alloc_res  alloc_q[$];     // results still owed by the block
    int          fail_count = 0;

    task automatic init_table();
        for (int i = 0; i < NSEG; i++) begin
            tbl_owner[i] = '0;
            tbl_len[i]   = '0;
            tbl_age[i]   = '0;
        end
        tbl_len[0] = total_units;
        n_segs     = 1;
        n_procs    = '0;
        n_holes    = 6'd1;
        units_used = '0;
    endtask

    // A zero size is ignored; anything else restarts the table.
    task automatic write_total_units(logic [15:0] v);
        if (v != 16'd0) begin
            total_units = v;
            init_table();
        end
    endtask

    function automatic int find_block(logic [15:0] id);
        for (int i = 0; i < n_segs; i++)
            if (tbl_owner[i] == {1'b1, id})
                return i;
        return -1;
    endfunction

    task automatic drop_seg(int i);
        for (int j = i; j + 1 < n_segs; j++) begin
            tbl_owner[j] = tbl_owner[j+1];
            tbl_len[j]   = tbl_len[j+1];
            tbl_age[j]   = tbl_age[j+1];
        end
        n_segs--;
        tbl_owner[n_segs] = '0;
        tbl_len[n_segs]   = '0;
        tbl_age[n_segs]   = '0;
    endtask

    task automatic open_hole(int i, logic [15:0] len);
        for (int j = n_segs; j > i; j--) begin
            tbl_owner[j] = tbl_owner[j-1];
            tbl_len[j]   = tbl_len[j-1];
            tbl_age[j]   = tbl_age[j-1];
        end
        tbl_owner[i] = '0;
        tbl_len[i]   = len;
        tbl_age[i]   = '0;
        n_segs++;
    endtask

    // Free a block and coalesce with the hole after it, then the one before.
    task automatic release_block(int i);
        tbl_owner[i] = '0;
        tbl_age[i]   = '0;
        n_procs--;
        n_holes++;
        units_used -= tbl_len[i];
        if (i + 1 < n_segs && !tbl_owner[i+1][16]) begin
            tbl_len[i] += tbl_len[i+1];
            drop_seg(i + 1);
            n_holes--;
        end
        if (i > 0 && !tbl_owner[i-1][16]) begin
            tbl_len[i-1] += tbl_len[i];
            drop_seg(i);
            n_holes--;
        end
    endtask

    // Largest block, oldest on a tie, lowest address on a full tie.
    function automatic int largest_block();
        int best = -1;
        for (int i = 0; i < n_segs; i++) begin
            if (!tbl_owner[i][16])
                continue;
            if (best < 0 || tbl_len[i] > tbl_len[best] ||
                (tbl_len[i] == tbl_len[best] && tbl_age[i] > tbl_age[best]))
                best = i;
        end
        return best;
    endfunction

    task automatic owe(logic ev, logic [15:0] eid, logic [2:0] st, logic last);
        t_alloc_res r;
        r.ev    = ev;
        r.eid   = eid;
        r.st    = st;
        r.last  = last;
        r.procs = n_procs;
        r.holes = n_holes;
        r.used  = units_used;
        alloc_q.push_back(r);
    endtask

    task automatic place_process(logic [15:0] id, logic [15:0] size);
        int h;
        int v;
        if (find_block(id) >= 0) begin
            owe(1'b0, '0, ST_RESIDENT, 1'b1);
            return;
        end
        if (size == 16'd0 || size > total_units) begin
            owe(1'b0, '0, ST_TOOBIG, 1'b1);
            return;
        end
        forever begin
            h = -1;
            for (int i = 0; i < n_segs; i++)
                if (!tbl_owner[i][16] && tbl_len[i] >= size) begin
                    h = i;
                    break;
                end
            if (h >= 0)
                break;
            v = largest_block();
            if (v < 0) begin
                owe(1'b0, '0, ST_TOOBIG, 1'b1);
                return;
            end
            begin
                logic [15:0] vid;
                vid = tbl_owner[v][15:0];
                release_block(v);
                owe(1'b1, vid, ST_PLACED, 1'b0);
            end
        end
        if (tbl_len[h] > size) begin
            // a split needs one more entry; the evictions above still stand
            if (n_segs >= NSEG) begin
                owe(1'b0, '0, ST_FULL, 1'b1);
                return;
            end
            open_hole(h + 1, tbl_len[h] - size);
            tbl_len[h] = size;
        end else begin
            n_holes--;
        end
        tbl_owner[h] = {1'b1, id};
        tbl_age[h]   = '0;
        n_procs++;
        units_used += size;
        owe(1'b0, '0, ST_PLACED, 1'b1);
    endtask

    task automatic predict_request(t_job j);
        int p;
        case (j.cmd)
            CMD_PLACE: place_process(j.pid, j.size);
            CMD_REMOVE: begin
                p = find_block(j.pid);
                if (p < 0) begin
                    owe(1'b0, '0, ST_NOTFOUND, 1'b1);
                end else begin
                    release_block(p);
                    owe(1'b0, '0, ST_REMOVED, 1'b1);
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < n_segs; i++)
                    if (tbl_owner[i][16] && tbl_age[i] != 32'hFFFF_FFFF)
                        tbl_age[i]++;
                owe(1'b0, '0, ST_TICKED, 1'b1);
            end
            default: ;  // unused command: no result at all
        endcase
    endtask

    // ---------------------------------------------------------------
    // Driver: feed requests from the pending queue, hold size writes
    // until the block has gone quiet
    // ---------------------------------------------------------------
    int drv_gap = 0;
    int drv_quiet = 0;
    int drv_sent = 0;

    always @(posedge i_clk) begin : drv
        logic nv;
        logic load;
        logic nwe;
        t_job hd;
        if (i_rst_n) begin
            nv   = in_valid;
            load = 1'b0;
            nwe  = 1'b0;
            if (in_valid && !o_in_stall) begin
                predict_request('{K_REQ, cmd, pid, req_size});
                nv = 1'b0;
            end
            if (!nv && pending.size() > 0) begin
                hd = pending[0];
                case (hd.kind)
                    K_REQ: begin
                        if (drv_gap > 0) begin
                            drv_gap--;
                        end else begin
                            nv   = 1'b1;
                            load = 1'b1;
                            void'(pending.pop_front());
                            drv_sent++;
                            // every fifty requests, a stretch with no gaps
                            drv_gap = (drv_sent % 50 < 15) ? 0 : $urandom_range(0, 13);
                        end
                    end
                    K_CFG: begin
                        if (drv_quiet >= SETTLE) begin
                            nwe = 1'b1;
                            write_total_units(hd.size);
                            void'(pending.pop_front());
                        end
                    end
                    default: begin
                        // pause the sender until every result is back
                        if (alloc_q.size() == 0)
                            void'(pending.pop_front());
                    end
                endcase
            end
            if (alloc_q.size() == 0 && !nv && !in_valid && !nwe)
                drv_quiet++;
            else
                drv_quiet = 0;
            in_valid <= nv;
            cfg_we   <= nwe;
            if (nwe)
                cfg_data <= hd.size;
            if (load) begin
                cmd      <= hd.cmd;
                pid      <= hd.pid;
                req_size <= hd.size;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random stall per result, one long hold-off, field checks
    // ---------------------------------------------------------------
    int mon_wait = 0;
    int mon_hold = 0;
    bit hold_done = 1'b0;
    int mon_count = 0;

    always @(posedge i_clk) begin : mon
        t_alloc_res e;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                mon_count++;
                if (alloc_q.size() == 0) begin
                    $error("result with nothing owed: status %0d", o_status);
                    fail_count++;
                end else begin
                    e = alloc_q.pop_front();
                    if (o_evicted_valid !== e.ev) begin
                        $error("evicted_valid exp %0d got %0d", e.ev, o_evicted_valid);
                        fail_count++;
                    end
                    if (o_evicted_id !== e.eid) begin
                        $error("evicted_id exp %0d got %0d", e.eid, o_evicted_id);
                        fail_count++;
                    end
                    if (o_status !== e.st) begin
                        $error("status exp %0d got %0d", e.st, o_status);
                        fail_count++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, o_last);
                        fail_count++;
                    end
                    if (o_proc_count !== e.procs) begin
                        $error("proc_count exp %0d got %0d", e.procs, o_proc_count);
                        fail_count++;
                    end
                    if (o_hole_count !== e.holes) begin
                        $error("hole_count exp %0d got %0d", e.holes, o_hole_count);
                        fail_count++;
                    end
                    if (o_used_memory !== e.used) begin
                        $error("used_memory exp %0d got %0d", e.used, o_used_memory);
                        fail_count++;
                    end
                end
                mon_wait = (mon_count % 60 < 20) ? 0 : $urandom_range(0, 13);
            end else if (o_out_valid && mon_wait > 0) begin
                mon_wait--;
            end
            // one long hold-off so the block backs up and stalls its input
            if (mon_hold > 0)
                mon_hold--;
            else if (!hold_done && mon_count >= 120) begin
                mon_hold  = HOLD_LEN;
                hold_done = 1'b1;
            end
            out_stall <= (mon_hold > 0) || (mon_wait > 0);
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WD_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    logic [15:0] id_pool [40];

    task automatic add_req(logic [1:0] c, logic [15:0] id, logic [15:0] sz);
        pending.push_back('{K_REQ, c, id, sz});
    endtask

    task automatic add_size_write(logic [15:0] v);
        pending.push_back('{K_CFG, CMD_PLACE, 16'd0, v});
    endtask

    task automatic add_drain();
        pending.push_back('{K_DRAIN, CMD_PLACE, 16'd0, 16'd0});
    endtask

    // Mostly a small pool of ids so that removes and repeats hit; small
    // memories get tiny sizes so the table can run out of entries.
    task automatic add_random(logic [15:0] msz, int pool_n);
        int          r;
        logic [1:0]  c;
        logic [15:0] id;
        logic [15:0] sz;
        r = $urandom_range(0, 99);
        c = (r < 55) ? CMD_PLACE : (r < 77) ? CMD_REMOVE : (r < 94) ? CMD_TICK : CMD_UNUSED;
        id = ($urandom_range(0, 6) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, pool_n-1)];
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0: sz = 16'd0;
                1: sz = msz;
                2: sz = (msz == 16'hFFFF) ? msz : msz + 16'd1;
                default: sz = 16'hFFFF;
            endcase
        end else if (msz <= 64)
            sz = 16'($urandom_range(1, 2));
        else if (r < 80)
            sz = 16'($urandom_range(1, (msz / 8 > 1) ? msz / 8 : 1));
        else
            sz = 16'($urandom_range(1, msz));
        add_req(c, id, sz);
    endtask

    task automatic add_phase(logic [15:0] msz, int n, int pool_n);
        for (int k = 0; k < n; k++) begin
            add_random(msz, pool_n);
            if (k == n / 2)
                add_drain();
        end
    endtask

    initial begin
        logic [15:0] cur_size;
        total_units = RESET_TOTAL;
        init_table();
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        id_pool[2] = 16'hAAAA;
        id_pool[3] = 16'h5555;
        for (int i = 4; i < 40; i++)
            id_pool[i] = 16'($urandom);

        // directed: exact fit, eviction, repeats, bad sizes, merges, unused cmd
        add_req(CMD_PLACE, 16'h0000, 16'd1024);
        add_req(CMD_PLACE, 16'hFFFF, 16'd1);
        add_req(CMD_PLACE, 16'hFFFF, 16'd5);
        add_req(CMD_PLACE, 16'h0007, 16'd0);
        add_req(CMD_PLACE, 16'h0007, 16'd1025);
        add_req(CMD_PLACE, 16'h0007, 16'hFFFF);
        add_req(CMD_REMOVE, 16'h0009, 16'd0);
        add_req(CMD_REMOVE, 16'hFFFF, 16'd0);
        add_req(CMD_TICK, 16'h0000, 16'd0);
        add_req(CMD_UNUSED, 16'h1234, 16'd77);
        add_req(CMD_PLACE, 16'h0001, 16'd100);
        add_req(CMD_PLACE, 16'h0002, 16'd200);
        add_req(CMD_PLACE, 16'h0003, 16'd100);
        add_req(CMD_PLACE, 16'h0005, 16'd200);
        add_req(CMD_TICK, 16'h0000, 16'd0);
        add_req(CMD_REMOVE, 16'h0002, 16'd0);
        add_req(CMD_PLACE, 16'h0004, 16'd700);
        add_req(CMD_REMOVE, 16'h0001, 16'd0);
        add_req(CMD_REMOVE, 16'h0003, 16'd0);
        add_req(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        add_drain();

        // size settings: extremes, an ignored zero, small tables, random
        add_phase(RESET_TOTAL, 40, 8);
        add_size_write(16'hFFFF);
        add_phase(16'hFFFF, 45, 12);
        add_size_write(16'd1);
        add_phase(16'd1, 30, 4);
        add_size_write(16'd0);
        add_phase(16'd1, 15, 4);
        add_size_write(16'd40);
        add_phase(16'd40, 60, 40);
        add_size_write(16'd64);
        add_phase(16'd64, 60, 40);
        cur_size = 16'($urandom_range(200, 60000));
        add_size_write(cur_size);
        add_phase(cur_size, 50, 16);
        add_size_write(RESET_TOTAL);
        add_phase(RESET_TOTAL, 50, 24);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(pending.size() == 0 && !in_valid && alloc_q.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && alloc_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
